FILE: sv/bssr_pkg.sv
// ----------------------------------------------------------------------------
// bssr_pkg
// shared types and constants for the baffle-step shelf response block
// ----------------------------------------------------------------------------
package bssr_pkg;

  localparam int FREQ_W  = 24;
  localparam int WIDTH_W = 13;
  localparam int N_W     = FREQ_W + WIDTH_W;   // exact product freq * width
  localparam int REAL_W  = 18;
  localparam int IMAG_W  = 16;
  localparam int B_W     = 28;                 // b in q.16, always below 2^28

  // 2^51 / (256 * 115000 * sqrt2), rounded
  localparam logic [25:0] BSCALE = 26'd54085018;

  // settings register indexes
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_NEUTRAL = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // item handed from the front to the back
  typedef struct packed {
    logic [N_W-1:0] n;
    status_t        status;
  } front_item_t;

endpackage

FILE: sv/bssr_front.sv
// ----------------------------------------------------------------------------
// bssr_front
// classifies each item against the settings and forms freq * width
// ----------------------------------------------------------------------------
module bssr_front (
  input  logic                         cfg_enable,
  input  logic [bssr_pkg::WIDTH_W-1:0] cfg_width,
  input  logic [bssr_pkg::FREQ_W-1:0]  freq,
  output bssr_pkg::front_item_t        item
);
  import bssr_pkg::*;

  always_comb begin
    item.n = N_W'(freq) * N_W'(cfg_width);
    if (!cfg_enable) begin
      item.status = ST_NEUTRAL;
    end else if (cfg_width == '0) begin
      item.status = ST_INVALID;
    end else begin
      item.status = ST_VALID;
    end
  end

endmodule

FILE: sv/bssr_queue.sv
// ----------------------------------------------------------------------------
// bssr_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module bssr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  bssr_pkg::front_item_t wr_item,
  output logic                  full,
  input  logic                  rd_en,
  output logic                  not_empty,
  output bssr_pkg::front_item_t rd_item
);
  import bssr_pkg::*;

  front_item_t slot_r [0:1];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_item   = slot_r[rptr_r];
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;

  always_comb begin
    wptr_nxt = wptr_r ^ do_wr;
    rptr_nxt = rptr_r ^ do_rd;
    cnt_nxt  = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_item;
    end
  end

endmodule

FILE: sv/bssr_back.sv
// ----------------------------------------------------------------------------
// bssr_back
// pipelined scaling, squaring and two restoring dividers, one step per stage
// ----------------------------------------------------------------------------
module bssr_back #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  bssr_pkg::front_item_t       q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bssr_pkg::REAL_W-1:0] out_resp_real,
  output logic [bssr_pkg::IMAG_W-1:0] out_resp_imag,
  output logic [1:0]                  out_status
);
  import bssr_pkg::*;

  localparam int S   = OUT_FRAC_BITS + 1;   // quotient bits, one per stage
  localparam int RW  = (S + 1 > REAL_W) ? S + 1 : REAL_W;
  localparam int IW  = (S > IMAG_W) ? S : IMAG_W;
  localparam int LO  = 19;
  localparam int DEN_W = 57;
  localparam int REM_W = 58;

  logic adv;

  // scaling stage: partial products of n * bscale
  logic          v1_r;
  status_t       st1_r;
  logic [LO+25:0]       plo_r;
  logic [N_W-LO+25:0]   phi_r;
  // b stage
  logic          v2_r;
  status_t       st2_r;
  logic [B_W-1:0] b_r;
  logic [63:0]   bsum;
  // square stage
  logic          v3_r;
  status_t       st3_r;
  logic [2*B_W-1:0] b2_r;
  logic [B_W-1:0]   bq_r;

  // divider stages
  logic             dv_r  [0:S];
  status_t          dst_r [0:S];
  logic [DEN_W-1:0] den_r [0:S];
  logic [REM_W-1:0] rr_r  [0:S];
  logic [REM_W-1:0] ri_r  [0:S];
  logic [S-1:0]     qr_r  [0:S];
  logic [S-1:0]     qi_r  [0:S];
  logic [REM_W-1:0] rr_nxt [1:S];
  logic [REM_W-1:0] ri_nxt [1:S];
  logic [S-1:0]     qr_nxt [1:S];
  logic [S-1:0]     qi_nxt [1:S];

  logic                  ov_r;
  logic [REAL_W-1:0]     ore_r;
  logic [IMAG_W-1:0]     oim_r;
  status_t               ost_r;
  logic [S:0]            rnd_re, rnd_im;
  logic [RW-1:0]         one_w, re_w;
  logic [IW-1:0]         im_w;

  assign adv   = !ov_r || out_ready;
  assign q_pop = adv && q_valid;

  assign bsum = (64'(phi_r) << LO) + 64'(plo_r) + (64'd1 << 34);

  // one restoring step per stage, stages are independent
  always_comb begin
    logic [REM_W-1:0] sr, si;
    for (int k = 1; k <= S; k++) begin
      sr = {rr_r[k-1][REM_W-2:0], 1'b0};
      si = {ri_r[k-1][REM_W-2:0], 1'b0};
      if (sr >= {1'b0, den_r[k-1]}) begin
        rr_nxt[k] = sr - {1'b0, den_r[k-1]};
        qr_nxt[k] = {qr_r[k-1][S-2:0], 1'b1};
      end else begin
        rr_nxt[k] = sr;
        qr_nxt[k] = {qr_r[k-1][S-2:0], 1'b0};
      end
      if (si >= {1'b0, den_r[k-1]}) begin
        ri_nxt[k] = si - {1'b0, den_r[k-1]};
        qi_nxt[k] = {qi_r[k-1][S-2:0], 1'b1};
      end else begin
        ri_nxt[k] = si;
        qi_nxt[k] = {qi_r[k-1][S-2:0], 1'b0};
      end
    end
  end

  // round to nearest, ties up, and format
  always_comb begin
    rnd_re = ({1'b0, qr_r[S]} + (S+1)'(1)) >> 1;
    rnd_im = ({1'b0, qi_r[S]} + (S+1)'(1)) >> 1;
    one_w  = RW'(1) << OUT_FRAC_BITS;
    re_w   = one_w + RW'(rnd_re);
    im_w   = IW'(rnd_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
      for (int k = 0; k <= S; k++) dv_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r    <= q_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      dv_r[0] <= v3_r;
      for (int k = 1; k <= S; k++) dv_r[k] <= dv_r[k-1];
      ov_r    <= dv_r[S];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r <= q_item.status;
      plo_r <= (LO+26)'(q_item.n[LO-1:0]) * (LO+26)'(BSCALE);
      phi_r <= (N_W-LO+26)'(q_item.n[N_W-1:LO]) * (N_W-LO+26)'(BSCALE);
      st2_r <= st1_r;
      b_r   <= bsum[62:35];
      st3_r <= st2_r;
      b2_r  <= (2*B_W)'(b_r) * (2*B_W)'(b_r);
      bq_r  <= b_r;
      dst_r[0] <= st3_r;
      den_r[0] <= (DEN_W'(1) << 32) + DEN_W'(b2_r);
      rr_r[0]  <= REM_W'(b2_r);
      ri_r[0]  <= REM_W'({bq_r, 16'b0});
      qr_r[0]  <= '0;
      qi_r[0]  <= '0;
      for (int k = 1; k <= S; k++) begin
        dst_r[k] <= dst_r[k-1];
        den_r[k] <= den_r[k-1];
        rr_r[k]  <= rr_nxt[k];
        ri_r[k]  <= ri_nxt[k];
        qr_r[k]  <= qr_nxt[k];
        qi_r[k]  <= qi_nxt[k];
      end
      ost_r <= dst_r[S];
      if (dst_r[S] == ST_VALID) begin
        ore_r <= re_w[REAL_W-1:0];
        oim_r <= im_w[IMAG_W-1:0];
      end else begin
        ore_r <= one_w[REAL_W-1:0];
        oim_r <= '0;
      end
    end
  end

  assign out_valid     = ov_r;
  assign out_resp_real = ore_r;
  assign out_resp_imag = oim_r;
  assign out_status    = ost_r;

endmodule

FILE: sv/baffle_step_shelf_response.sv
// ----------------------------------------------------------------------------
// baffle_step_shelf_response
// evaluates the baffle-step shelf (1 + j f/fz) / (1 + j f/fp) per item
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_freq_q8
//  out     | output    | out_valid / out_ready| out_resp_real, out_resp_imag, out_status
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
//  one item per cycle sustained while out_ready is high; the back pipeline
//  holds a divider chain of one restoring step per stage
//  reset clears the settings (disabled, width zero) and all valid bits
//  a stalled output freezes the whole back pipeline; the two-entry queue
//  keeps in_ready high until it holds two items
// ----------------------------------------------------------------------------
module baffle_step_shelf_response #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bssr_pkg::FREQ_W-1:0]  in_freq_q8,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bssr_pkg::REAL_W-1:0]  out_resp_real,
  output logic [bssr_pkg::IMAG_W-1:0]  out_resp_imag,
  output logic [1:0]                   out_status,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bssr_pkg::WIDTH_W-1:0] cfg_wdata
);
  import bssr_pkg::*;

  // settings registers
  logic               enable_r;
  logic [WIDTH_W-1:0] width_r;

  front_item_t f_item, q_item;
  logic        q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      width_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        default:    ;   // unknown index ignored
      endcase
    end
  end

  // front: classify and form freq * width
  bssr_front u_front (
    .cfg_enable (enable_r),
    .cfg_width  (width_r),
    .freq       (in_freq_q8),
    .item       (f_item)
  );

  assign in_ready = !q_full;

  bssr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_valid),
    .wr_item   (f_item),
    .full      (q_full),
    .rd_en     (q_pop),
    .not_empty (q_valid),
    .rd_item   (q_item)
  );

  // back: scaling, square, dividers, output register
  bssr_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_resp_real (out_resp_real),
    .out_resp_imag (out_resp_imag),
    .out_status    (out_status)
  );

endmodule

FILE: sv/bssr_checker.sv
// ----------------------------------------------------------------------------
// bssr_checker
// port-level checks on the shelf response block
// ----------------------------------------------------------------------------
module bssr_checker #(
  parameter int OUT_FRAC_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bssr_pkg::REAL_W-1:0]  out_resp_real,
  input logic [bssr_pkg::IMAG_W-1:0]  out_resp_imag,
  input logic [1:0]                   out_status
);
  import bssr_pkg::*;

  localparam logic [REAL_W-1:0] ONE = REAL_W'(64'd1 << OUT_FRAC_BITS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_resp_real)
      && $stable(out_resp_imag) && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_VALID || out_status == ST_NEUTRAL
      || out_status == ST_INVALID)
    else $error("bad status code");

  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_VALID |-> out_resp_real == ONE && out_resp_imag == '0)
    else $error("neutral result not unity");

  a_shelf_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_VALID && OUT_FRAC_BITS == 16
      |-> out_resp_real >= ONE)
    else $error("shelf real part below unity");

  // the queue only fills behind a held result
  a_full_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked without a waiting result");

endmodule

bind baffle_step_shelf_response bssr_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chk (.*);
